// ===== rtl/dcsa_pkg.sv =====
package dcsa_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int TRACK_BITS_DEF = 16;
	localparam int TAG_BITS_DEF   = 8;
	localparam int STATUS_W       = 3;

	localparam logic KIND_REQ = 1'b0;
	localparam logic KIND_REL = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_GRANTED = 3'd0,
		STAT_QUEUED  = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_NEXT    = 3'd3,
		STAT_IDLE    = 3'd4,
		STAT_IGNORED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_WAIT,
		S_FREE,
		S_SCAN,
		S_LAST,
		S_PICK,
		S_PUT
	} fsm_t;

endpackage

// ===== rtl/dcsa_req_if.sv =====
interface dcsa_req_if #(
	parameter int TRACK_BITS = 16,
	parameter int TAG_BITS   = 8
);
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [TRACK_BITS-1:0] track;
	logic [TAG_BITS-1:0]   requester;

	modport source (output valid, kind, track, requester, input ready);
	modport sink   (input valid, kind, track, requester, output ready);
endinterface

// ===== rtl/dcsa_rsp_if.sv =====
interface dcsa_rsp_if
	import dcsa_pkg::*;
#(
	parameter int TRACK_BITS = 16,
	parameter int TAG_BITS   = 8
);
	logic                  valid;
	logic                  ready;
	status_t               status;
	logic [TRACK_BITS-1:0] grant_track;
	logic [TAG_BITS-1:0]   grant_requester;

	modport source (output valid, status, grant_track, grant_requester, input ready);
	modport sink   (input valid, status, grant_track, grant_requester, output ready);
endinterface

// ===== rtl/dcsa_ram.sv =====
module dcsa_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/dcsa_scan.sv =====
// running C-SCAN pick over slots streamed in ascending order
module dcsa_scan #(
	parameter int TRACK_BITS = 16,
	parameter int TAG_BITS   = 8,
	parameter int IDX_W      = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr,
	input  logic                  en,
	input  logic [TRACK_BITS-1:0] head,
	input  logic [TRACK_BITS-1:0] track,
	input  logic [TAG_BITS-1:0]   tag,
	input  logic [IDX_W-1:0]      idx,
	output logic                  found,
	output logic [TRACK_BITS-1:0] pick_track,
	output logic [TAG_BITS-1:0]   pick_tag,
	output logic [IDX_W-1:0]      pick_slot
);
	logic                  up_f_q, low_f_q;
	logic [TRACK_BITS-1:0] up_trk_q, low_trk_q;
	logic [TAG_BITS-1:0]   up_tag_q, low_tag_q;
	logic [IDX_W-1:0]      up_idx_q, low_idx_q;
	logic                  take_up, take_low;

	// strict less-than keeps the lowest slot on equal tracks
	assign take_up  = en && (track >= head) && (!up_f_q || (track < up_trk_q));
	assign take_low = en && (!low_f_q || (track < low_trk_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_f_q  <= 1'b0;
			low_f_q <= 1'b0;
		end else if (clr) begin
			up_f_q  <= 1'b0;
			low_f_q <= 1'b0;
		end else begin
			if (take_up) up_f_q <= 1'b1;
			if (take_low) low_f_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_up) begin
			up_trk_q <= track;
			up_tag_q <= tag;
			up_idx_q <= idx;
		end
		if (take_low) begin
			low_trk_q <= track;
			low_tag_q <= tag;
			low_idx_q <= idx;
		end
	end

	assign found      = up_f_q || low_f_q;
	assign pick_track = up_f_q ? up_trk_q : low_trk_q;
	assign pick_tag   = up_f_q ? up_tag_q : low_tag_q;
	assign pick_slot  = up_f_q ? up_idx_q : low_idx_q;
endmodule

// ===== rtl/disk_cscan_request_arbiter_top.sv =====
// C-SCAN disk arm arbiter. A request on an idle disk is granted at once;
// otherwise it is stored in the lowest free of SLOTS table entries (or rejected
// when the table is full). A release on a busy disk grants the smallest
// waiting track at or above the current head, wrapping to the smallest
// waiting track, or idles the disk; a release on an idle disk is ignored.
// One transaction is handled at a time: a queued request searches for a free
// slot one valid bit per cycle, and a release on a busy disk reads the slot
// RAM one entry per cycle. The result sits in an output register, so the next
// transaction may start while it waits; a result that finds the register still
// occupied holds the block until the receiver takes the earlier one.
module disk_cscan_request_arbiter_top
	import dcsa_pkg::*;
#(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int TRACK_BITS = TRACK_BITS_DEF,
	parameter int TAG_BITS   = TAG_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	dcsa_req_if.sink   req,
	dcsa_rsp_if.source rsp
);
	localparam int IDX_W = $clog2(SLOTS);
	localparam int ENT_W = TRACK_BITS + TAG_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	fsm_t st_q, st_d;
	logic [IDX_W-1:0]      idx_q;
	logic                  busy_q;
	logic [TRACK_BITS-1:0] head_q;
	logic [SLOTS-1:0]      valid_q;
	logic [TRACK_BITS-1:0] req_trk_q;
	logic [TAG_BITS-1:0]   req_tag_q;
	status_t               res_st_q;
	logic [TRACK_BITS-1:0] res_trk_q;
	logic [TAG_BITS-1:0]   res_tag_q;
	logic                  ov_q;
	status_t               o_st_q;
	logic [TRACK_BITS-1:0] o_trk_q;
	logic [TAG_BITS-1:0]   o_tag_q;
	logic                  rd_v_s1, slot_v_s1;
	logic [IDX_W-1:0]      idx_s1;

	logic                  in_acc, ram_we, ram_re, out_load, slot_free;
	logic [ENT_W-1:0]      ram_rdata;
	logic                  pk_found;
	logic [TRACK_BITS-1:0] pk_trk;
	logic [TAG_BITS-1:0]   pk_tag;
	logic [IDX_W-1:0]      pk_slot;

	assign req.ready = (st_q == S_WAIT);
	assign in_acc    = req.valid && req.ready;
	assign slot_free = !valid_q[idx_q];

	always_comb begin
		st_d     = st_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		unique case (st_q)
			S_WAIT: begin
				if (req.valid) begin
					if (req.kind == KIND_REQ) st_d = busy_q ? S_FREE : S_PUT;
					else st_d = busy_q ? S_SCAN : S_PUT;
				end
			end
			S_FREE: begin
				if (slot_free) begin
					ram_we = 1'b1;
					st_d   = S_PUT;
				end else if (idx_q == LAST_IDX) begin
					st_d = S_PUT;
				end
			end
			S_SCAN: begin
				ram_re = 1'b1;
				if (idx_q == LAST_IDX) st_d = S_LAST;
			end
			S_LAST: st_d = S_PICK;
			S_PICK: st_d = S_PUT;
			S_PUT: begin
				if (!ov_q || rsp.ready) begin
					out_load = 1'b1;
					st_d     = S_WAIT;
				end
			end
			default: st_d = S_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_WAIT;
			idx_q     <= '0;
			busy_q    <= 1'b0;
			head_q    <= '0;
			valid_q   <= '0;
			ov_q      <= 1'b0;
			rd_v_s1   <= 1'b0;
		end else begin
			st_q    <= st_d;
			rd_v_s1 <= ram_re;
			if (in_acc) begin
				idx_q <= '0;
				if (req.kind == KIND_REQ && !busy_q) begin
					busy_q <= 1'b1;
					head_q <= req.track;
				end
			end
			if (st_q == S_FREE) begin
				if (slot_free) valid_q[idx_q] <= 1'b1;
				else idx_q <= idx_q + 1'b1;
			end
			if (st_q == S_SCAN && idx_q != LAST_IDX) idx_q <= idx_q + 1'b1;
			if (st_q == S_PICK) begin
				if (pk_found) begin
					valid_q[pk_slot] <= 1'b0;
					head_q           <= pk_trk;
				end else begin
					busy_q <= 1'b0;
				end
			end
			if (out_load) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		slot_v_s1 <= valid_q[idx_q];
		idx_s1    <= idx_q;
		if (in_acc) begin
			req_trk_q <= req.track;
			req_tag_q <= req.requester;
			if (req.kind == KIND_REQ) begin
				res_st_q  <= STAT_GRANTED;
				res_trk_q <= req.track;
				res_tag_q <= req.requester;
			end else begin
				res_st_q  <= STAT_IGNORED;
				res_trk_q <= '0;
				res_tag_q <= '0;
			end
		end
		if (st_q == S_FREE) begin
			res_trk_q <= '0;
			res_tag_q <= '0;
			res_st_q  <= slot_free ? STAT_QUEUED : STAT_FULL;
		end
		if (st_q == S_PICK) begin
			res_st_q  <= pk_found ? STAT_NEXT : STAT_IDLE;
			res_trk_q <= pk_found ? pk_trk : '0;
			res_tag_q <= pk_found ? pk_tag : '0;
		end
		if (out_load) begin
			o_st_q  <= res_st_q;
			o_trk_q <= res_trk_q;
			o_tag_q <= res_tag_q;
		end
	end

	dcsa_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata({req_trk_q, req_tag_q}),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	dcsa_scan #(
		.TRACK_BITS(TRACK_BITS),
		.TAG_BITS  (TAG_BITS),
		.IDX_W     (IDX_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (in_acc),
		.en        (rd_v_s1 && slot_v_s1),
		.head      (head_q),
		.track     (ram_rdata[ENT_W-1:TAG_BITS]),
		.tag       (ram_rdata[TAG_BITS-1:0]),
		.idx       (idx_s1),
		.found     (pk_found),
		.pick_track(pk_trk),
		.pick_tag  (pk_tag),
		.pick_slot (pk_slot)
	);

	assign rsp.valid           = ov_q;
	assign rsp.status          = o_st_q;
	assign rsp.grant_track     = o_trk_q;
	assign rsp.grant_requester = o_tag_q;
endmodule

// ===== rtl/dcsa_checker.sv =====
module dcsa_checker
	import dcsa_pkg::*;
#(
	parameter int TRACK_BITS = TRACK_BITS_DEF,
	parameter int TAG_BITS   = TAG_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input status_t               status,
	input logic [TRACK_BITS-1:0] grant_track,
	input logic [TAG_BITS-1:0]   grant_requester
);
	// one transaction in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous transaction in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_GRANTED || status == STAT_QUEUED ||
			status == STAT_FULL || status == STAT_NEXT ||
			status == STAT_IDLE || status == STAT_IGNORED))
		else $error("bad status code");

	a_no_grant_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_QUEUED || status == STAT_FULL ||
			status == STAT_IDLE || status == STAT_IGNORED)
		|-> (grant_track == '0 && grant_requester == '0))
		else $error("grant fields set without a grant");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("stalled result dropped or changed");
endmodule

bind disk_cscan_request_arbiter_top dcsa_checker #(
	.TRACK_BITS(TRACK_BITS),
	.TAG_BITS  (TAG_BITS)
) u_dcsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.status         (rsp.status),
	.grant_track    (rsp.grant_track),
	.grant_requester(rsp.grant_requester)
);
